/* sv/sitf_pkg.sv */
// Shared types, widths and helper functions for the spherical interface trap force block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sitf_pkg;

  // Field widths.
  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int SUM_W     = 48;
  localparam int CFG_W     = 31;
  localparam int COS_W     = 16;
  localparam int COS_FRAC  = 14;
  localparam int UNIT_SH   = 30;
  localparam int PI_SH     = 30;
  localparam int DIFF_W    = COORD_W + 1;

  // Serial multiplier: a is held, b is consumed one bit per cycle.
  localparam int MUL_A_W   = 56;
  localparam int MUL_B_W   = 36;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = 6;
  localparam int SH_W      = 5;

  // Square root and divider.
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = 32;
  localparam int REM_W     = 34;
  localparam int DIV_N_W   = 34;
  localparam int DIV_Q_W   = 31;
  localparam int STEP_W    = 5;

  // Intermediate results.
  localparam int KP_W      = 34;
  localparam int CS_W      = 34;
  localparam int Z_W       = 34;
  localparam int OPD_W     = 36;
  localparam int FW_W      = 53;
  localparam int V_W       = 51;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_GAMMA  = 3'd0;
  localparam logic [2:0] REG_COS    = 3'd1;
  localparam logic [2:0] REG_SIGMA  = 3'd2;
  localparam logic [2:0] REG_CX     = 3'd3;
  localparam logic [2:0] REG_CY     = 3'd4;
  localparam logic [2:0] REG_CZ     = 3'd5;
  localparam logic [2:0] REG_RADIUS = 3'd6;

  typedef struct packed {
    logic            start;
    logic [SH_W-1:0] shift;
  } mul_req_t;

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x[63] ? -x : x;
  endfunction

  // Magnitude and sign to a signed SUM_W value, saturated.
  function automatic logic [SUM_W-1:0] clamp_sum(input logic [MUL_P_W-1:0] m,
                                                 input logic neg);
    logic [MUL_P_W-1:0] lim;
    lim = {{(MUL_P_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    if (!neg) begin
      return (m > lim) ? {1'b0, {(SUM_W-1){1'b1}}} : m[SUM_W-1:0];
    end
    return (m > lim + MUL_P_W'(1)) ? {1'b1, {(SUM_W-1){1'b0}}}
                                    : (~m[SUM_W-1:0] + SUM_W'(1));
  endfunction

  // Magnitude and sign to a signed COORD_W value, saturated.
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [MUL_P_W-1:0] m,
                                                     input logic neg);
    logic [MUL_P_W-1:0] lim;
    lim = {{(MUL_P_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    if (!neg) begin
      return (m > lim) ? {1'b0, {(COORD_W-1){1'b1}}} : m[COORD_W-1:0];
    end
    return (m > lim + MUL_P_W'(1)) ? {1'b1, {(COORD_W-1){1'b0}}}
                                    : (~m[COORD_W-1:0] + COORD_W'(1));
  endfunction

  // Saturating signed add at SUM_W bits.
  function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/sitf_mul.sv */
// Bit-serial shift-and-add multiplier with a rounding right shift at the end.
// Depends on sitf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitf_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sitf_pkg::mul_req_t             req_i,
  input  logic [sitf_pkg::MUL_A_W-1:0]   a_i,
  input  logic [sitf_pkg::MUL_B_W-1:0]   b_i,
  output logic [sitf_pkg::MUL_P_W-1:0]   prod_o,
  output logic                           done_o
);
  import sitf_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_RND  = 2'd2;

  logic [1:0]           st_q, st_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [MUL_P_W-1:0]   p_q, p_d;
  logic [MUL_A_W-1:0]   a_q;
  logic [SH_W-1:0]      sh_q;
  logic [MUL_A_W:0]     upper;
  logic [MUL_P_W:0]     half, rnd, shr;

  always_comb begin
    upper = {1'b0, p_q[MUL_P_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    half  = (sh_q == '0) ? '0 : ((MUL_P_W+1)'(1) << (sh_q - SH_W'(1)));
    rnd   = {1'b0, p_q} + half;
    shr   = rnd >> sh_q;
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    p_d    = p_q;
    case (st_q)
      M_IDLE: begin
        if (req_i.start) begin
          p_d   = {{MUL_A_W{1'b0}}, b_i};
          cnt_d = MUL_CNT_W'(MUL_B_W - 1);
          st_d  = M_RUN;
        end
      end
      M_RUN: begin
        p_d = {upper, p_q[MUL_B_W-1:1]};
        if (cnt_q == '0) begin
          st_d = M_RND;
        end else begin
          cnt_d = cnt_q - MUL_CNT_W'(1);
        end
      end
      M_RND: begin
        p_d    = shr[MUL_P_W-1:0];
        done_d = 1'b1;
        st_d   = M_IDLE;
      end
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (st_q == M_IDLE && req_i.start) begin
      a_q  <= a_i;
      sh_q <= req_i.shift;
    end
  end

  assign prod_o = p_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* sv/sitf_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on sitf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitf_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sitf_pkg::SQ_W-1:0]    val_i,
  output logic [sitf_pkg::ROOT_W-1:0]  root_o,
  output logic                         done_o
);
  import sitf_pkg::*;

  logic                busy_q, done_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [SQ_W-1:0]     v_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [REM_W+1:0]    rem4, trial, diff;
  logic                ge;

  always_comb begin
    rem4  = {rem_q, v_q[SQ_W-1:SQ_W-2]};
    trial = {2'b00, root_q, 2'b01};
    ge    = (rem4 >= trial);
    diff  = rem4 - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(ROOT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      v_q    <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      v_q    <= {v_q[SQ_W-3:0], 2'b00};
      rem_q  <= ge ? diff[REM_W-1:0] : rem4[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* sv/sitf_div.sv */
// Restoring divider lane, one quotient bit per cycle, for the unit-vector components.
// Depends on sitf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sitf_pkg::DIV_N_W-1:0]  num_i,
  input  logic [sitf_pkg::ROOT_W-1:0]   den_i,
  output logic [sitf_pkg::DIV_Q_W-1:0]  quo_o,
  output logic                          done_o
);
  import sitf_pkg::*;

  logic                busy_q, done_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [DIV_N_W-1:0]  r_q, rem;
  logic [ROOT_W-1:0]   den_q;
  logic [DIV_Q_W-1:0]  q_q;
  logic                ge;

  always_comb begin
    ge  = (r_q >= {{(DIV_N_W-ROOT_W){1'b0}}, den_q});
    rem = ge ? (r_q - {{(DIV_N_W-ROOT_W){1'b0}}, den_q}) : r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(DIV_Q_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      r_q   <= num_i;
      den_q <= den_i;
      q_q   <= '0;
    end else if (busy_q) begin
      r_q <= {rem[DIV_N_W-2:0], 1'b0};
      q_q <= {q_q[DIV_Q_W-2:0], ge};
    end
  end

  assign quo_o  = q_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* sv/sphere_interface_trap_force.sv */
// A particle outside the group goes straight to the output. Otherwise each item uses the
// shared serial multiplier (one bit of the short operand per cycle), the square root and,
// in band and off the centre, the unit-vector divide.
// The block takes one item at a time and stalls its input until the item is handed on.
// Reset clears the configuration registers, both running sums and all handshake state.
`timescale 1ns / 1ps
`default_nettype none

module sphere_interface_trap_force (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [sitf_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [sitf_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [sitf_pkg::COORD_W-1:0] pos_z_i,
  input  logic                           in_group_i,
  input  logic                           start_pass_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [sitf_pkg::COORD_W-1:0] force_dx_o,
  output logic signed [sitf_pkg::COORD_W-1:0] force_dy_o,
  output logic signed [sitf_pkg::COORD_W-1:0] force_dz_o,
  output logic                           in_band_o,
  output logic                           at_centre_o,
  output logic signed [sitf_pkg::SUM_W-1:0]   energy_total_o,
  output logic signed [sitf_pkg::SUM_W-1:0]   force_total_o
);
  import sitf_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_MUL_GO    = 3'd1;
  localparam logic [2:0] S_MUL_WAIT  = 3'd2;
  localparam logic [2:0] S_SQRT_GO   = 3'd3;
  localparam logic [2:0] S_SQRT_WAIT = 3'd4;
  localparam logic [2:0] S_DIV_GO    = 3'd5;
  localparam logic [2:0] S_DIV_WAIT  = 3'd6;
  localparam logic [2:0] S_OUT       = 3'd7;

  // Multiply operations, issued in this order. The groups are contiguous so that
  // the sequencer steps through each group by incrementing.
  localparam logic [3:0] OP_SQX = 4'd0;
  localparam logic [3:0] OP_SQY = 4'd1;
  localparam logic [3:0] OP_SQZ = 4'd2;
  localparam logic [3:0] OP_KP  = 4'd3;
  localparam logic [3:0] OP_CS  = 4'd4;
  localparam logic [3:0] OP_FW  = 4'd5;
  localparam logic [3:0] OP_V   = 4'd6;
  localparam logic [3:0] OP_E   = 4'd7;
  localparam logic [3:0] OP_FX  = 4'd8;
  localparam logic [3:0] OP_FY  = 4'd9;
  localparam logic [3:0] OP_FZ  = 4'd10;

  // Configuration registers.
  logic [CFG_W-1:0]          gamma_q, sigma_q, radius_q;
  logic signed [COS_W-1:0]   cos_q;
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;

  // Control.
  logic [2:0] state_q;
  logic [3:0] op_q;
  logic       out_valid_q;
  logic       cfg_wr;

  // Working registers for the item in flight.
  logic signed [DIFF_W-1:0]  dx_q, dy_q, dz_q;
  logic                      grp_q, start_q, band_q, centre_q;
  logic [SQ_W-1:0]           ssum_q;
  logic [KP_W-1:0]           kp_q;
  logic signed [CS_W-1:0]    cs_q;
  logic signed [FW_W-1:0]    fw_q;
  logic [SUM_W-1:0]          fw48_q, e_q;
  logic signed [V_W-1:0]     v_q;
  logic [COORD_W-1:0]        fx_q, fy_q, fz_q;

  // Running sums and the output register.
  logic [SUM_W-1:0]          esum_q, fsum_q;
  logic [COORD_W-1:0]        ofx_q, ofy_q, ofz_q;
  logic                      oband_q, ocentre_q;

  // Unit connections.
  mul_req_t                  mul_req;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_neg;
  logic [MUL_P_W-1:0]        mul_p;
  logic                      mul_done;
  logic [ROOT_W-1:0]         root;
  logic                      sqrt_done;
  logic [DIV_Q_W-1:0]        qx, qy, qz;
  logic                      dvx_done, dvy_done, dvz_done, div_done;

  // Derived values for the current item.
  logic [63:0]               ab_x, ab_y, ab_z, ab_cos, ab_csmz, ab_z0, ab_z2c, ab_v, ab_fw;
  logic signed [Z_W-1:0]     z0, sig34, nsig34;
  logic signed [OPD_W-1:0]   csmz, z2c;
  logic                      band_now;
  logic [SQ_W:0]             ssum_add;
  logic [SQ_W-1:0]           ssum_base, ssum_new;
  logic [SUM_W-1:0]          e_base, f_base;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Register reads.
  always_comb begin
    case (paddr[4:2])
      REG_GAMMA:  prdata = {1'b0, gamma_q};
      REG_COS:    prdata = {{(32-COS_W){cos_q[COS_W-1]}}, cos_q};
      REG_SIGMA:  prdata = {1'b0, sigma_q};
      REG_CX:     prdata = cx_q;
      REG_CY:     prdata = cy_q;
      REG_CZ:     prdata = cz_q;
      REG_RADIUS: prdata = {1'b0, radius_q};
      default:    prdata = '0;
    endcase
  end

  // Distance to the interface and the band test. The square root output is held
  // until the next item starts, so z0 stays valid for the rest of the item.
  always_comb begin
    z0       = {3'b000, radius_q} - {2'b00, root};
    sig34    = {3'b000, sigma_q};
    nsig34   = -sig34;
    band_now = (z0 > nsig34) && (z0 < sig34);
    csmz     = {{(OPD_W-CS_W){cs_q[CS_W-1]}}, cs_q} - {{(OPD_W-Z_W){z0[Z_W-1]}}, z0};
    z2c      = {{(OPD_W-Z_W){z0[Z_W-1]}}, z0} - {cs_q[CS_W-1], cs_q, 1'b0};
    ab_x     = abs64(dx_q);
    ab_y     = abs64(dy_q);
    ab_z     = abs64(dz_q);
    ab_cos   = abs64(cos_q);
    ab_csmz  = abs64(csmz);
    ab_z0    = abs64(z0);
    ab_z2c   = abs64(z2c);
    ab_v     = abs64(v_q);
    ab_fw    = abs64(fw_q);
  end

  // Operand selection for the shared multiplier. Each product is formed on
  // magnitudes; the sign is applied when the result is stored.
  always_comb begin
    mul_req.start = (state_q == S_MUL_GO);
    mul_req.shift = '0;
    mul_a         = '0;
    mul_b         = '0;
    mul_neg       = 1'b0;
    case (op_q)
      OP_SQX: begin
        mul_a = ab_x[MUL_A_W-1:0];
        mul_b = ab_x[MUL_B_W-1:0];
      end
      OP_SQY: begin
        mul_a = ab_y[MUL_A_W-1:0];
        mul_b = ab_y[MUL_B_W-1:0];
      end
      OP_SQZ: begin
        mul_a = ab_z[MUL_A_W-1:0];
        mul_b = ab_z[MUL_B_W-1:0];
      end
      OP_KP: begin
        mul_a         = MUL_A_W'(PI_Q30);
        mul_b         = MUL_B_W'(gamma_q);
        mul_req.shift = SH_W'(PI_SH);
      end
      OP_CS: begin
        mul_a         = ab_cos[MUL_A_W-1:0];
        mul_b         = MUL_B_W'(sigma_q);
        mul_req.shift = SH_W'(COS_FRAC);
        mul_neg       = cos_q[COS_W-1];
      end
      OP_FW: begin
        mul_a         = MUL_A_W'({kp_q, 1'b0});
        mul_b         = ab_csmz[MUL_B_W-1:0];
        mul_req.shift = SH_W'(FRAC_W);
        mul_neg       = csmz[OPD_W-1];
      end
      OP_V: begin
        mul_a         = ab_z0[MUL_A_W-1:0];
        mul_b         = ab_z2c[MUL_B_W-1:0];
        mul_req.shift = SH_W'(FRAC_W);
        mul_neg       = z0[Z_W-1] ^ z2c[OPD_W-1];
      end
      OP_E: begin
        mul_a         = ab_v[MUL_A_W-1:0];
        mul_b         = MUL_B_W'(kp_q);
        mul_req.shift = SH_W'(FRAC_W);
        mul_neg       = v_q[V_W-1];
      end
      OP_FX: begin
        mul_a         = ab_fw[MUL_A_W-1:0];
        mul_b         = MUL_B_W'(qx);
        mul_req.shift = SH_W'(UNIT_SH);
        mul_neg       = fw_q[FW_W-1] ^ dx_q[DIFF_W-1];
      end
      OP_FY: begin
        mul_a         = ab_fw[MUL_A_W-1:0];
        mul_b         = MUL_B_W'(qy);
        mul_req.shift = SH_W'(UNIT_SH);
        mul_neg       = fw_q[FW_W-1] ^ dy_q[DIFF_W-1];
      end
      OP_FZ: begin
        mul_a         = ab_fw[MUL_A_W-1:0];
        mul_b         = MUL_B_W'(qz);
        mul_req.shift = SH_W'(UNIT_SH);
        mul_neg       = fw_q[FW_W-1] ^ dz_q[DIFF_W-1];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The sum of squares saturates at the top of 64 bits; such a particle always
  // lies outside the band.
  always_comb begin
    ssum_base = (op_q == OP_SQX) ? '0 : ssum_q;
    ssum_add  = {1'b0, ssum_base} + {1'b0, mul_p[SQ_W-1:0]};
    ssum_new  = (ssum_add[SQ_W] || (mul_p[MUL_P_W-1:SQ_W] != '0)) ? '1
                                                                  : ssum_add[SQ_W-1:0];
    e_base    = start_q ? '0 : esum_q;
    f_base    = start_q ? '0 : fsum_q;
  end

  sitf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p),
    .done_o (mul_done)
  );

  sitf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_SQRT_GO),
    .val_i   (ssum_q),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  // Three divider lanes run side by side, one per axis.
  sitf_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIV_GO),
    .num_i   (ab_x[DIV_N_W-1:0]),
    .den_i   (root),
    .quo_o   (qx),
    .done_o  (dvx_done)
  );

  sitf_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIV_GO),
    .num_i   (ab_y[DIV_N_W-1:0]),
    .den_i   (root),
    .quo_o   (qy),
    .done_o  (dvy_done)
  );

  sitf_div u_div_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIV_GO),
    .num_i   (ab_z[DIV_N_W-1:0]),
    .den_i   (root),
    .quo_o   (qz),
    .done_o  (dvz_done)
  );

  assign div_done = dvx_done & dvy_done & dvz_done;

  // Sequencer, configuration registers and running sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_SQX;
      out_valid_q <= 1'b0;
      esum_q      <= '0;
      fsum_q      <= '0;
      gamma_q     <= '0;
      cos_q       <= '0;
      sigma_q     <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      radius_q    <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_GAMMA:  gamma_q  <= pwdata[CFG_W-1:0];
          REG_COS:    cos_q    <= pwdata[COS_W-1:0];
          REG_SIGMA:  sigma_q  <= pwdata[CFG_W-1:0];
          REG_CX:     cx_q     <= pwdata[COORD_W-1:0];
          REG_CY:     cy_q     <= pwdata[COORD_W-1:0];
          REG_CZ:     cz_q     <= pwdata[COORD_W-1:0];
          REG_RADIUS: radius_q <= pwdata[CFG_W-1:0];
          default:    ;
        endcase
      end
      // A finished item takes the output register as soon as it is free or being
      // emptied in this same cycle.
      if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= OP_SQX;
            state_q <= in_group_i ? S_MUL_GO : S_OUT;
          end
        end
        S_MUL_GO: state_q <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mul_done) begin
            case (op_q)
              OP_CS:   state_q <= S_SQRT_GO;
              OP_E:    state_q <= centre_q ? S_OUT : S_DIV_GO;
              OP_FZ:   state_q <= S_OUT;
              default: begin
                op_q    <= op_q + 4'd1;
                state_q <= S_MUL_GO;
              end
            endcase
          end
        end
        S_SQRT_GO: state_q <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sqrt_done) begin
            if (band_now) begin
              op_q    <= OP_FW;
              state_q <= S_MUL_GO;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            op_q    <= OP_FX;
            state_q <= S_MUL_GO;
          end
        end
        S_OUT: begin
          // The finished item waits here until the output register is free.
          if (!out_valid_q || !out_stall_i) begin
            esum_q      <= band_q ? sat_add_sum(e_base, e_q) : e_base;
            fsum_q      <= band_q ? sat_add_sum(f_base, fw48_q) : f_base;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      dx_q     <= {pos_x_i[COORD_W-1], pos_x_i} - {cx_q[COORD_W-1], cx_q};
      dy_q     <= {pos_y_i[COORD_W-1], pos_y_i} - {cy_q[COORD_W-1], cy_q};
      dz_q     <= {pos_z_i[COORD_W-1], pos_z_i} - {cz_q[COORD_W-1], cz_q};
      grp_q    <= in_group_i;
      start_q  <= start_pass_i;
      band_q   <= 1'b0;
      centre_q <= 1'b0;
    end
    if (state_q == S_SQRT_WAIT && sqrt_done) begin
      band_q   <= band_now;
      centre_q <= (root == '0);
    end
    if (state_q == S_MUL_WAIT && mul_done) begin
      case (op_q)
        OP_SQX, OP_SQY, OP_SQZ: ssum_q <= ssum_new;
        OP_KP: kp_q <= mul_p[KP_W-1:0];
        OP_CS: cs_q <= mul_neg ? -mul_p[CS_W-1:0] : mul_p[CS_W-1:0];
        OP_FW: begin
          fw_q   <= mul_neg ? -mul_p[FW_W-1:0] : mul_p[FW_W-1:0];
          fw48_q <= clamp_sum(mul_p, mul_neg);
        end
        OP_V:  v_q  <= mul_neg ? -mul_p[V_W-1:0] : mul_p[V_W-1:0];
        OP_E:  e_q  <= clamp_sum(mul_p, mul_neg);
        OP_FX: fx_q <= clamp_coord(mul_p, mul_neg);
        OP_FY: fy_q <= clamp_coord(mul_p, mul_neg);
        OP_FZ: fz_q <= clamp_coord(mul_p, mul_neg);
        default: ;
      endcase
    end
    if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
      // At the centre or outside the band the force components are zero.
      ofx_q     <= (band_q && !centre_q) ? fx_q : '0;
      ofy_q     <= (band_q && !centre_q) ? fy_q : '0;
      ofz_q     <= (band_q && !centre_q) ? fz_q : '0;
      oband_q   <= band_q;
      ocentre_q <= centre_q && grp_q;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign force_dx_o     = ofx_q;
  assign force_dy_o     = ofy_q;
  assign force_dz_o     = ofz_q;
  assign in_band_o      = oband_q;
  assign at_centre_o    = ocentre_q;
  assign energy_total_o = esum_q;
  assign force_total_o  = fsum_q;

  // A particle at the centre never receives a force.
  a_centre_no_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_centre_o |-> force_dx_o == '0 && force_dy_o == '0 && force_dz_o == '0)
    else $error("force given to a particle at the centre");

  // Outside the band every force component is zero.
  a_band_no_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_band_o |-> force_dx_o == '0 && force_dy_o == '0 && force_dz_o == '0)
    else $error("force given to a particle outside the band");

  // The multiplier only finishes while the sequencer waits for it.
  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL_WAIT)
    else $error("multiplier finished outside its wait state");

  // The square root only finishes while the sequencer waits for it.
  a_sqrt_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == S_SQRT_WAIT)
    else $error("square root finished outside its wait state");

  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("accepted item did not start");

endmodule

`default_nettype wire

/* bench/sphere_interface_trap_force_tb.sv */
// Self-checking testbench for the spherical interface trap force block.
// Carries its own fixed-point model of the force, flags and both running sums; needs sitf_pkg.
`timescale 1ns / 1ps

module sphere_interface_trap_force_tb;
  import sitf_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam longint PI_FIX = 64'sd3373259426;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint CRD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [COORD_W-1:0] fx, fy, fz;
    logic               band, centre;
    logic [SUM_W-1:0]   energy, fsum;
  } trap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COORD_W-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic in_group_i = 1'b0, start_pass_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [COORD_W-1:0] force_dx_o, force_dy_o, force_dz_o;
  logic in_band_o, at_centre_o;
  logic signed [SUM_W-1:0] energy_total_o, force_total_o;

  sphere_interface_trap_force uut (.*);

  // Model copy of the configuration registers and the running sums.
  longint gamma_q, cos_q, sigma_q, cx_q, cy_q, cz_q, radius_q;
  longint energy_acc, magnitude_acc;

  trap_result_t pending_results[$];
  int mismatches = 0;
  int items_sent = 0, results_seen = 0, band_hits = 0, centre_hits = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int cycles = 0;

  initial forever #2 clk_i = ~clk_i;

  // The watchdog assumes the slowest legal run fits well inside the limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // The result side stalls at the current rate; zero means it never stalls.
  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [63:0] umag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // (a*b) >> sh, rounded half away from zero, saturated to 64 bits.
  function automatic longint mul_round(longint a, longint b, int sh);
    logic [127:0] p;
    logic neg;
    neg = (a < 0) != (b < 0);
    p = {64'd0, umag(a)} * {64'd0, umag(b)};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'(I64_MAX)) return neg ? -I64_MAX : I64_MAX;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] usat_add(logic [63:0] a, logic [63:0] b);
    return (a + b < a) ? '1 : a + b;
  endfunction

  function automatic longint clamp_to(longint v, longint hi);
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint sum_add(longint a, longint b);
    a = clamp_to(a, SUM_MAX);
    b = clamp_to(b, SUM_MAX);
    if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
    if (b < 0 && a < -SUM_MAX - 1 - b) return -SUM_MAX - 1;
    return a + b;
  endfunction

  // Component of the force along one axis: fwall times the unit offset, rounded.
  function automatic logic [COORD_W-1:0] axis_force(longint fwall, longint d,
                                                    logic [63:0] dis);
    logic [63:0] q;
    longint u;
    q = (umag(d) << UNIT_SH) / dis;
    u = d < 0 ? -longint'(q) : longint'(q);
    return COORD_W'(clamp_to(mul_round(fwall, u, UNIT_SH), CRD_MAX));
  endfunction

  // Computes the expected result of one particle and advances the model's sums.
  function automatic trap_result_t trap_force_of(logic signed [COORD_W-1:0] px, py, pz,
                                                 logic grp, logic restart);
    trap_result_t r;
    longint dx, dy, dz, z0, kp, cs, fwall, v;
    logic [63:0] sq, dis;
    dx = longint'(px) - cx_q;
    dy = longint'(py) - cy_q;
    dz = longint'(pz) - cz_q;
    r.fx = '0; r.fy = '0; r.fz = '0; r.band = 1'b0; r.centre = 1'b0;
    if (restart) begin
      energy_acc = 0;
      magnitude_acc = 0;
    end
    if (grp) begin
      sq = usat_add(usat_add(umag(dx) * umag(dx), umag(dy) * umag(dy)), umag(dz) * umag(dz));
      dis = int_sqrt(sq);
      z0 = radius_q - longint'(dis);
      r.centre = (dis == 0);
      if (z0 > -sigma_q && z0 < sigma_q) begin
        kp = mul_round(PI_FIX, gamma_q, PI_SH);
        cs = mul_round(cos_q, sigma_q, COS_FRAC);
        fwall = mul_round(2 * kp, cs - z0, FRAC_W);
        v = mul_round(z0, z0 - 2 * cs, FRAC_W);
        r.band = 1'b1;
        if (!r.centre) begin
          r.fx = axis_force(fwall, dx, dis);
          r.fy = axis_force(fwall, dy, dis);
          r.fz = axis_force(fwall, dz, dis);
        end
        energy_acc = sum_add(energy_acc, mul_round(kp, v, FRAC_W));
        magnitude_acc = sum_add(magnitude_acc, fwall);
      end
    end
    r.energy = SUM_W'(energy_acc);
    r.fsum = SUM_W'(magnitude_acc);
    return r;
  endfunction

  // Every accepted result is matched against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    trap_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("Result with no item outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        band_hits <= band_hits + exp_r.band;
        centre_hits <= centre_hits + exp_r.centre;
        if (force_dx_o !== exp_r.fx || force_dy_o !== exp_r.fy || force_dz_o !== exp_r.fz ||
            in_band_o !== exp_r.band || at_centre_o !== exp_r.centre ||
            energy_total_o !== exp_r.energy || force_total_o !== exp_r.fsum) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("Mismatch: force exp %h %h %h got %h %h %h", exp_r.fx, exp_r.fy,
                     exp_r.fz, force_dx_o, force_dy_o, force_dz_o);
            $display("  band/centre exp %b%b got %b%b, energy exp %h got %h, sum exp %h got %h",
                     exp_r.band, exp_r.centre, in_band_o, at_centre_o, exp_r.energy,
                     energy_total_o, exp_r.fsum, force_total_o);
          end
        end
      end
    end
  end

  // Register write: a setup phase, then the access phase that commits it.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GAMMA:  gamma_q = longint'(value[30:0]);
      REG_COS:    cos_q = longint'(signed'(value[15:0]));
      REG_SIGMA:  sigma_q = longint'(value[30:0]);
      REG_CX:     cx_q = longint'(signed'(value));
      REG_CY:     cy_q = longint'(signed'(value));
      REG_CZ:     cz_q = longint'(signed'(value));
      REG_RADIUS: radius_q = longint'(value[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] gam, logic [31:0] cosv, logic [31:0] sig,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] rad);
    write_reg(REG_GAMMA, gam);
    write_reg(REG_COS, cosv);
    write_reg(REG_SIGMA, sig);
    write_reg(REG_CX, x);
    write_reg(REG_CY, y);
    write_reg(REG_CZ, z);
    write_reg(REG_RADIUS, rad);
  endtask

  // Called at a clock edge; returns at the edge where the item was taken. Valid is
  // left high so a following item can go out back to back. While idling is on, the
  // sender skips each cycle with the given chance before it offers the item.
  task automatic send_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic grp, logic restart);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x; pos_y_i <= y; pos_z_i <= z;
    in_group_i <= grp; start_pass_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(trap_force_of(x, y, z, grp, restart));
    items_sent++;
  endtask

  // Holds the input side until every result is back, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // A particle placed at a random direction, at a distance within two band
  // half-widths of the interface.
  task automatic send_near_sphere(logic grp, logic restart);
    real vx, vy, vz, len, span;
    vx = real'(int'($urandom_range(2000)) - 1000);
    vy = real'(int'($urandom_range(2000)) - 1000);
    vz = real'(int'($urandom_range(2000)) - 1000);
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len == 0.0) begin
      vx = 1.0;
      len = 1.0;
    end
    span = real'(radius_q) + real'(sigma_q) * (real'(int'($urandom_range(4000)) - 2000) / 1000.0);
    send_particle(32'(cx_q + longint'(vx * span / len)), 32'(cy_q + longint'(vy * span / len)),
                  32'(cz_q + longint'(vz * span / len)), grp, restart);
  endtask

  task automatic random_config();
    logic [31:0] gam, cosv;
    gam = ($urandom_range(9) == 0) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0010_0000);
    cosv = ($urandom_range(9) == 0) ? $urandom : 32'(int'($urandom_range(32768)) - 16384);
    set_config(gam, cosv, $urandom_range(0, 20 << 16),
               32'(int'($urandom_range(20000 << 16)) - (10000 << 16)),
               32'(int'($urandom_range(20000 << 16)) - (10000 << 16)),
               32'(int'($urandom_range(20000 << 16)) - (10000 << 16)),
               $urandom_range(0, 1000 << 16));
  endtask

  // Out of reset every register is zero, so nothing can be in the band.
  task automatic test_reset_state();
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, 1'b0);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    send_particle(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
    send_particle(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1, 1'b0, 1'b0);
    drain();
  endtask

  // Hand-placed particles around a sphere of radius 10 with a unit band half-width.
  task automatic test_band_edges();
    set_config(32'h0001_0000, 32'd8192, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h000A_0000);
    send_particle(32'h000A_0000, 32'h0, 32'h0, 1'b1, 1'b1);
    send_particle(32'h0, 32'hFFF7_0000, 32'h0, 1'b1, 1'b0);
    send_particle(32'h0, 32'h0, 32'h000B_0000, 1'b1, 1'b0);
    send_particle(32'h0009_0000, 32'h0, 32'h0, 1'b1, 1'b0);
    send_particle(32'h0, 32'h000A_FFFF, 32'h0, 1'b1, 1'b0);
    send_particle(32'h0009_0001, 32'h0, 32'h0, 1'b1, 1'b0);
    send_particle(32'h0006_0000, 32'h0008_0000, 32'h0, 1'b1, 1'b0);
    send_particle(32'h0006_0000, 32'h0008_0000, 32'h0, 1'b0, 1'b0);
    send_particle(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
    send_particle(32'hFFFA_0000, 32'h0, 32'hFFF8_8000, 1'b1, 1'b1);
    drain();
    // A sphere smaller than the band: the centre itself lies in the band.
    write_reg(REG_RADIUS, 32'h0000_8000);
    send_particle(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
    send_particle(32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
    drain();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_particle(32'h0000_4000, 32'h0, 32'h0, 1'b1, 1'b0);
    drain();
  endtask

  // Registers at their limits, including cosines outside the nominal range.
  task automatic test_extreme_config();
    set_config(32'h7FFF_FFFF, 32'h0000_7FFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h0, 32'h7FFF_FFFF);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    repeat (4) send_near_sphere(1'b1, 1'b0);
    drain();
    set_config(32'h7FFF_FFFF, 32'hFFFF_8000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h0);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    drain();
    set_config(32'h7FFF_FFFF, 32'hFFFF_C000, 32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0100_0000);
    repeat (6) send_near_sphere(1'b1, 1'b0);
    drain();
  endtask

  // Mostly particles near the interface, plus full-range noise, non-members and particles at the centre.
  task automatic test_random_traffic(int count, int tx_idle, int rx_stall);
    int kind;
    send_idle_pct = tx_idle;
    recv_stall_pct = rx_stall;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        drain();
        random_config();
      end
      kind = $urandom_range(99);
      if (kind < 62) begin
        send_near_sphere(1'b1, $urandom_range(29) == 0);
      end else if (kind < 77) begin
        send_particle($urandom, $urandom, $urandom, 1'b1, $urandom_range(29) == 0);
      end else if (kind < 90) begin
        send_particle($urandom, $urandom, $urandom, 1'b0, $urandom_range(1));
      end else begin
        send_particle(32'(cx_q), 32'(cy_q), 32'(cz_q), $urandom_range(1), 1'b0);
      end
    end
    drain();
  endtask

  initial begin
    gamma_q = 0; cos_q = 0; sigma_q = 0; cx_q = 0; cy_q = 0; cz_q = 0; radius_q = 0;
    energy_acc = 0; magnitude_acc = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_band_edges();
    test_extreme_config();
    test_random_traffic(580, 35, 82);
    test_random_traffic(580, 82, 35);
    test_random_traffic(580, 0, 0);
    repeat (600) @(posedge clk_i);
    $display("Sent %0d particles, checked %0d results (%0d in band, %0d at the centre).",
             items_sent, results_seen, band_hits, centre_hits);
    $display("Mismatches: %0d, results still outstanding: %0d.", mismatches,
             pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
